[rtl/core/gct_pkg.sv]
// Package for the grid coverage tracker: constants, types and helper functions.
package gct_pkg;

  localparam int unsigned MaxRows   = 64;
  localparam int unsigned MaxCols   = 64;
  localparam int unsigned MaxAgents = 16;
  localparam int unsigned NumMarks  = 7;

  localparam int unsigned RowW   = $clog2(MaxRows);
  localparam int unsigned ColW   = $clog2(MaxCols);
  localparam int unsigned MapW   = RowW + ColW;
  localparam int unsigned AgentW = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgGridRows  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridCols  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCellWidth = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCellHeight = 2'd3;

  localparam logic [1:0] OpUpdate = 2'd0;
  localparam logic [1:0] OpCheck  = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  localparam logic [30:0] MoveMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  agent;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [2:0]  mark_index;
  } in_word_t;

  typedef struct packed {
    logic [12:0] covered_cells;
    logic [30:0] move_count;
    logic [3:0]  new_cells;
    logic [6:0]  marks_reached_now;
    logic        nearly_full;
    logic signed [31:0] mark_moves;
  } out_word_t;

  typedef enum logic [3:0] {
    StIdle, StDiv, StAgent, StSweepRd, StSweepWr, StCheck, StOut
  } state_e;

  // Divider handshake between the top level and the divider.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  // Milestone percentage by index.
  function automatic logic [6:0] mark_pct(input logic [2:0] i);
    logic [6:0] p;
    unique case (i)
      3'd0: p = 7'd50;
      3'd1: p = 7'd60;
      3'd2: p = 7'd70;
      3'd3: p = 7'd80;
      3'd4: p = 7'd90;
      3'd5: p = 7'd95;
      default: p = 7'd99;
    endcase
    return p;
  endfunction

endpackage

[rtl/core/gct_if.sv]
// Valid/ready channel carrying one word of payload.
interface gct_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/gct_div.sv]
// Two restoring dividers running in parallel, one quotient bit per cycle.
module gct_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gct_pkg::div_ctl_t ctl_i,
  input  logic [15:0] num_x_i,
  input  logic [15:0] den_x_i,
  input  logic [15:0] num_y_i,
  input  logic [15:0] den_y_i,
  output logic        busy_o,
  output logic [15:0] quo_x_o,
  output logic [15:0] quo_y_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] qx_q, qx_d, qy_q, qy_d;
  logic [16:0] rx_q, rx_d, ry_q, ry_d;
  logic [15:0] dx_q, dy_q;
  logic [16:0] tx, ty;

  // Shift in one numerator bit and try a subtract on each lane
  always_comb begin
    cnt_d = cnt_q;
    qx_d = qx_q;
    qy_d = qy_q;
    rx_d = rx_q;
    ry_d = ry_q;
    tx = {rx_q[15:0], qx_q[15]};
    ty = {ry_q[15:0], qy_q[15]};
    if (ctl_i.start) begin
      cnt_d = 5'd16;
      qx_d = num_x_i;
      qy_d = num_y_i;
      rx_d = '0;
      ry_d = '0;
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      if (tx >= {1'b0, dx_q}) begin
        rx_d = tx - {1'b0, dx_q};
        qx_d = {qx_q[14:0], 1'b1};
      end else begin
        rx_d = tx;
        qx_d = {qx_q[14:0], 1'b0};
      end
      if (ty >= {1'b0, dy_q}) begin
        ry_d = ty - {1'b0, dy_q};
        qy_d = {qy_q[14:0], 1'b1};
      end else begin
        ry_d = ty;
        qy_d = {qy_q[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d;
    qy_q <= qy_d;
    rx_q <= rx_d;
    ry_q <= ry_d;
    if (ctl_i.start) begin
      dx_q <= den_x_i;
      dy_q <= den_y_i;
    end
  end

  assign busy_o  = (cnt_q != 5'd0);
  assign quo_x_o = qx_q;
  assign quo_y_o = qy_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_o) else $error("divider restarted while busy");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !ctl_i.start) |=> (cnt_q == $past(cnt_q) - 5'd1))
    else $error("divider count skipped");
  a_start_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> (cnt_q == 5'd16)) else $error("divider start count wrong");

endmodule

[rtl/core/grid_coverage_tracker_core.sv]
// Top level of the grid coverage tracker: sequencer, bitmap memory and result register.
//
// Use: items arrive on in_if (op, agent, pos_x, pos_y, mark_index) and one result
// word leaves on out_if for every accepted item. Registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// A position update starts two 16-bit restoring divisions side by side the cycle
// after it is taken and waits for them, passes through one agent-table state,
// then sweeps the 3x3 cell neighborhood in the coverage bitmap with a read and a
// write state per cell, and loads the result register. A milestone check walks
// the seven milestones one a cycle; a read or an unused op goes straight to the
// result register. One item is in work at a time, and the next one can be taken
// in the cycle after the result leaves; the separate read and write states for
// each bitmap cell set the update time.
// After reset the bitmap is cleared by a pass over all 4096 entries, one entry a
// cycle, during which no item is accepted; registers may be written then.
// The result sits in an output register; while the receiver stalls it is
// held and no new item is taken.
module grid_coverage_tracker_core (
  input  logic clk_i,
  input  logic rst_ni,
  gct_if.sink   in_if,
  gct_if.source out_if,
  input  logic                         cfg_we_i,
  input  logic [gct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gct_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [6:0]  rows_q, cols_q;
  logic [15:0] cw_q, ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 7'd12;
      cols_q <= 7'd12;
      cw_q   <= 16'd1067;
      ch_q   <= 16'd800;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gct_pkg::CfgGridRows:   rows_q <= cfg_data_i[6:0];
        gct_pkg::CfgGridCols:   cols_q <= cfg_data_i[6:0];
        gct_pkg::CfgCellWidth:  cw_q   <= cfg_data_i;
        gct_pkg::CfgCellHeight: ch_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [6:0] rows_u, cols_u;
  assign rows_u = (rows_q > 7'd64) ? 7'd64 : rows_q;
  assign cols_u = (cols_q > 7'd64) ? 7'd64 : cols_q;

  // Control state
  gct_pkg::state_e st_q, st_d;
  gct_pkg::in_word_t it_q;
  logic        clr_q;
  logic [12:0] clr_cnt_q;
  logic [12:0] cov_q;
  logic [30:0] moves_q;
  logic [6:0]  flags_q;
  logic [30:0] rec_q [gct_pkg::NumMarks];
  logic [15:0] lrow_q [gct_pkg::MaxAgents];
  logic [15:0] lcol_q [gct_pkg::MaxAgents];
  logic [gct_pkg::MaxAgents-1:0] lval_q;
  logic [3:0]  nbr_q;
  logic [3:0]  newc_q;
  logic [2:0]  mk_q;
  logic [6:0]  now_q;
  logic signed [16:0] row_q, col_q;
  logic        out_v_q;
  gct_pkg::out_word_t out_q;

  // Divider, started the cycle after an update is taken
  gct_pkg::div_ctl_t dctl;
  logic        div_busy;
  logic        div_go_q;
  logic [15:0] qx, qy, magx, magy;
  assign magx = it_q.pos_x[15] ? 16'(-it_q.pos_x) : it_q.pos_x;
  assign magy = it_q.pos_y[15] ? 16'(-it_q.pos_y) : it_q.pos_y;
  assign dctl.busy  = div_busy;
  assign dctl.start = div_go_q;

  gct_div u_div (
    .clk_i, .rst_ni, .ctl_i(dctl),
    .num_x_i(magx), .den_x_i((cw_q == 16'd0) ? 16'd1 : cw_q),
    .num_y_i(magy), .den_y_i((ch_q == 16'd0) ? 16'd1 : ch_q),
    .busy_o(div_busy), .quo_x_o(qx), .quo_y_o(qy)
  );

  logic signed [16:0] col_res, row_res;
  assign col_res = it_q.pos_x[15] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign row_res = it_q.pos_y[15] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  // Row and column offset of the sweep position, row by row over the 3x3 block
  logic [1:0] nb_dr, nb_dc;
  always_comb begin
    unique case (nbr_q)
      4'd0, 4'd1, 4'd2: nb_dr = 2'd0;
      4'd3, 4'd4, 4'd5: nb_dr = 2'd1;
      default:          nb_dr = 2'd2;
    endcase
    unique case (nbr_q)
      4'd0, 4'd3, 4'd6: nb_dc = 2'd0;
      4'd1, 4'd4, 4'd7: nb_dc = 2'd1;
      default:          nb_dc = 2'd2;
    endcase
  end

  // Neighborhood cell of the sweep
  logic signed [17:0] nr, nc;
  logic       n_in;
  logic [gct_pkg::MapW-1:0] n_addr;
  always_comb begin
    nr = 18'(row_q) + 18'($signed({1'b0, nb_dr})) - 18'sd1;
    nc = 18'(col_q) + 18'($signed({1'b0, nb_dc})) - 18'sd1;
    n_in = (nr >= 0) && (nr < $signed({11'd0, rows_u})) &&
           (nc >= 0) && (nc < $signed({11'd0, cols_u}));
    n_addr = {nr[gct_pkg::RowW-1:0], nc[gct_pkg::ColW-1:0]};
  end

  // Milestone test for the mark being walked and for 99 percent
  logic [13:0] total;
  logic [19:0] cov100;
  logic        reach_mk, reach99;
  assign total  = 14'(rows_u) * 14'(cols_u);
  assign cov100 = 20'(cov_q) * 20'd100;
  assign reach_mk = (total != 0) && (cov100 >= 20'(gct_pkg::mark_pct(mk_q)) * 20'(total));
  assign reach99  = (total != 0) && (cov100 >= 20'd99 * 20'(total));

  // Bitmap memory
  logic mem [1 << gct_pkg::MapW];
  logic mem_rd_q, mem_we;
  logic [gct_pkg::MapW-1:0] mem_wa;
  logic mem_wd;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[n_addr];
  end
  always_comb begin
    mem_we = 1'b0;
    mem_wa = n_addr;
    mem_wd = 1'b1;
    if (clr_q) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q[gct_pkg::MapW-1:0];
      mem_wd = 1'b0;
    end else if (st_q == gct_pkg::StSweepWr && n_in && !mem_rd_q) begin
      mem_we = 1'b1;
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      gct_pkg::StIdle: begin
        if (in_if.valid && !clr_q && !out_v_q) begin
          unique case (in_if.data.op)
            gct_pkg::OpUpdate: st_d = gct_pkg::StDiv;
            gct_pkg::OpCheck:  st_d = gct_pkg::StCheck;
            default:           st_d = gct_pkg::StOut;
          endcase
        end
      end
      gct_pkg::StDiv: begin
        if (!div_busy && !div_go_q) st_d = gct_pkg::StAgent;
      end
      gct_pkg::StAgent:   st_d = gct_pkg::StSweepRd;
      gct_pkg::StSweepRd: st_d = gct_pkg::StSweepWr;
      gct_pkg::StSweepWr: st_d = (nbr_q == 4'd8) ? gct_pkg::StOut : gct_pkg::StSweepRd;
      gct_pkg::StCheck:   st_d = (mk_q == 3'd6) ? gct_pkg::StOut : gct_pkg::StCheck;
      gct_pkg::StOut:     st_d = gct_pkg::StIdle;
      default:            st_d = gct_pkg::StIdle;
    endcase
  end

  assign in_if.ready = (st_q == gct_pkg::StIdle) && !clr_q && !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= gct_pkg::StIdle;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      cov_q <= '0;
      moves_q <= '0;
      flags_q <= '0;
      lval_q <= '0;
      out_v_q <= 1'b0;
      div_go_q <= 1'b0;
      for (int i = 0; i < int'(gct_pkg::NumMarks); i++) rec_q[i] <= '0;
      for (int i = 0; i < int'(gct_pkg::MaxAgents); i++) begin
        lrow_q[i] <= '0;
        lcol_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      div_go_q <= in_if.valid && in_if.ready && (in_if.data.op == gct_pkg::OpUpdate);
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 13'd1;
        if (clr_cnt_q == 13'((1 << gct_pkg::MapW) - 1)) clr_q <= 1'b0;
      end
      if (out_if.valid && out_if.ready) out_v_q <= 1'b0;
      // Agent table and move counter
      if (st_q == gct_pkg::StAgent && {1'b0, it_q.agent} < 5'(gct_pkg::MaxAgents)) begin
        if (lval_q[it_q.agent] && (lrow_q[it_q.agent] != row_res[15:0] ||
            lcol_q[it_q.agent] != col_res[15:0]) && moves_q != gct_pkg::MoveMax)
          moves_q <= moves_q + 31'd1;
        lval_q[it_q.agent] <= 1'b1;
        lrow_q[it_q.agent] <= row_res[15:0];
        lcol_q[it_q.agent] <= col_res[15:0];
      end
      if (mem_we && !clr_q) cov_q <= cov_q + 13'd1;
      // Milestones
      if (st_q == gct_pkg::StCheck && !flags_q[mk_q] && reach_mk) begin
        flags_q[mk_q] <= 1'b1;
        rec_q[mk_q] <= moves_q;
      end
      if (st_q == gct_pkg::StOut) out_v_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      it_q <= in_if.data;
      nbr_q <= '0;
      newc_q <= '0;
      mk_q <= '0;
      now_q <= '0;
    end
    if (st_q == gct_pkg::StAgent) begin
      row_q <= row_res;
      col_q <= col_res;
    end
    if (st_q == gct_pkg::StSweepWr) begin
      nbr_q <= nbr_q + 4'd1;
      if (mem_we) newc_q <= newc_q + 4'd1;
    end
    if (st_q == gct_pkg::StCheck) begin
      mk_q <= mk_q + 3'd1;
      if (!flags_q[mk_q] && reach_mk) now_q[mk_q] <= 1'b1;
    end
    if (st_q == gct_pkg::StOut) begin
      out_q.covered_cells <= cov_q;
      out_q.move_count <= moves_q;
      out_q.new_cells <= newc_q;
      out_q.marks_reached_now <= now_q;
      out_q.nearly_full <= reach99;
      out_q.mark_moves <= '0;
      if (it_q.op == gct_pkg::OpRead) begin
        if (it_q.mark_index != 3'd7 && flags_q[it_q.mark_index])
          out_q.mark_moves <= $signed({1'b0, rec_q[it_q.mark_index]});
        else
          out_q.mark_moves <= -32'sd1;
      end
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  a_no_accept_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_if.ready) else $error("item taken during clear");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_if.ready) |=> out_v_q) else $error("result dropped");
  a_cov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cov_q <= 13'd4096) else $error("covered count overflow");

endmodule

[tb/gct_checker.sv]
// Checker for the grid coverage tracker: predicts every result word and compares it.
module gct_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gct_if                                in_ch,
  gct_if                                out_ch,
  input  logic                          cfg_we_i,
  input  logic [gct_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gct_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);
  import gct_pkg::*;

  // Shadow copy of the block's registers and state
  logic [6:0]  rows_q, cols_q;
  logic [15:0] cell_w_q, cell_h_q;
  logic        cov_map [MaxRows*MaxCols];
  int          covered_q;
  int          agent_row [MaxAgents];
  int          agent_col [MaxAgents];
  logic        agent_seen [MaxAgents];
  logic [30:0] moves_q;
  logic [6:0]  mark_hit_q;
  logic [30:0] mark_moves_q [NumMarks];

  out_word_t   expected_words [$];

  function automatic int trunc_cell(logic signed [15:0] pos, logic [15:0] size);
    int d, m, q;
    d = (size == 0) ? 1 : int'(size);
    m = (pos < 0) ? -int'(pos) : int'(pos);
    q = m / d;
    return (pos < 0) ? -q : q;
  endfunction

  function automatic int rows_in_use();
    return (rows_q > MaxRows) ? MaxRows : int'(rows_q);
  endfunction

  function automatic int cols_in_use();
    return (cols_q > MaxCols) ? MaxCols : int'(cols_q);
  endfunction

  function automatic logic coverage_at(int pct);
    int total;
    total = rows_in_use() * cols_in_use();
    if (total == 0) return 1'b0;
    return covered_q * 100 >= pct * total;
  endfunction

  // Apply one input word to the shadow state and return the result word
  function automatic out_word_t track_word(in_word_t w);
    out_word_t r;
    int row, col, rr, cc, nr, nc, idx;
    r = '0;
    if (w.op == OpUpdate) begin
      col = trunc_cell(w.pos_x, cell_w_q);
      row = trunc_cell(w.pos_y, cell_h_q);
      nr = rows_in_use();
      nc = cols_in_use();
      if (agent_seen[w.agent] && (row != agent_row[w.agent] || col != agent_col[w.agent])) begin
        if (moves_q != MoveMax) moves_q++;
      end
      agent_seen[w.agent] = 1'b1;
      agent_row[w.agent] = row;
      agent_col[w.agent] = col;
      for (rr = row - 1; rr <= row + 1; rr++) begin
        for (cc = col - 1; cc <= col + 1; cc++) begin
          if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
            idx = rr * MaxCols + cc;
            if (!cov_map[idx]) begin
              cov_map[idx] = 1'b1;
              covered_q++;
              r.new_cells++;
            end
          end
        end
      end
    end else if (w.op == OpCheck) begin
      for (int i = 0; i < NumMarks; i++) begin
        if (!mark_hit_q[i] && coverage_at(int'(mark_pct(3'(i))))) begin
          mark_hit_q[i] = 1'b1;
          mark_moves_q[i] = moves_q;
          r.marks_reached_now[i] = 1'b1;
        end
      end
    end else if (w.op == OpRead) begin
      if (w.mark_index < NumMarks && mark_hit_q[w.mark_index])
        r.mark_moves = {1'b0, mark_moves_q[w.mark_index]};
      else
        r.mark_moves = -32'sd1;
    end
    r.covered_cells = 13'(covered_q);
    r.move_count = moves_q;
    r.nearly_full = coverage_at(99);
    return r;
  endfunction

  // Track registers, predict accepted words, compare returned words
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t got, exp_w;
    if (!rst_ni) begin
      rows_q = 7'd12;
      cols_q = 7'd12;
      cell_w_q = 16'd1067;
      cell_h_q = 16'd800;
      foreach (cov_map[i]) cov_map[i] = 1'b0;
      foreach (agent_seen[i]) begin
        agent_seen[i] = 1'b0;
        agent_row[i] = 0;
        agent_col[i] = 0;
      end
      covered_q = 0;
      moves_q = '0;
      mark_hit_q = '0;
      foreach (mark_moves_q[i]) mark_moves_q[i] = '0;
      expected_words.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGridRows:   rows_q = cfg_data_i[6:0];
          CfgGridCols:   cols_q = cfg_data_i[6:0];
          CfgCellWidth:  cell_w_q = cfg_data_i;
          CfgCellHeight: cell_h_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) expected_words.push_back(track_word(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_cnt_o++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got.covered_cells !== exp_w.covered_cells) begin
            $error("covered_cells: expected %0d, got %0d", exp_w.covered_cells, got.covered_cells);
            fail_cnt_o++;
          end
          if (got.move_count !== exp_w.move_count) begin
            $error("move_count: expected %0d, got %0d", exp_w.move_count, got.move_count);
            fail_cnt_o++;
          end
          if (got.new_cells !== exp_w.new_cells) begin
            $error("new_cells: expected %0d, got %0d", exp_w.new_cells, got.new_cells);
            fail_cnt_o++;
          end
          if (got.marks_reached_now !== exp_w.marks_reached_now) begin
            $error("marks_reached_now: expected %b, got %b",
                   exp_w.marks_reached_now, got.marks_reached_now);
            fail_cnt_o++;
          end
          if (got.nearly_full !== exp_w.nearly_full) begin
            $error("nearly_full: expected %0d, got %0d", exp_w.nearly_full, got.nearly_full);
            fail_cnt_o++;
          end
          if (got.mark_moves !== exp_w.mark_moves) begin
            $error("mark_moves: expected %0d, got %0d", exp_w.mark_moves, got.mark_moves);
            fail_cnt_o++;
          end
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the grid coverage tracker: clock, reset, stimulus and verdict.
module tb;
  import gct_pkg::*;

  localparam int CycleLimit = 600000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  fail_cnt;
  int                  pending;
  int                  cycles;
  logic                quiet;      // no idling on either side
  logic                hold_req;   // ask the receiver for a long stall
  int                  cur_rows, cur_cols, cur_w, cur_h;

  gct_if #(.T(in_word_t))  in_ch ();
  gct_if #(.T(out_word_t)) out_ch ();

  grid_coverage_tracker_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  gct_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Receiver: random stalls, plus one long counted hold on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req <= 1'b0;
        out_ch.ready <= 1'b1;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(negedge clk_i);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end
    end
  end

  // Offer one word after a random gap; return at the negedge after acceptance
  task automatic send_word(in_word_t w);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_grid(int rows, int cols, int w, int h);
    write_reg(CfgGridRows, 16'(rows));
    write_reg(CfgGridCols, 16'(cols));
    write_reg(CfgCellWidth, 16'(w));
    write_reg(CfgCellHeight, 16'(h));
    cur_rows = rows;
    cur_cols = cols;
    cur_w = w;
    cur_h = h;
  endtask

  // Position mostly near the grid, sometimes anywhere, sometimes negative
  function automatic logic [15:0] pick_pos(int size, int n);
    int lim, v;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    lim = ((size == 0) ? 1 : size) * ((n > 64 ? 64 : n) + 1);
    if (lim > 32767) lim = 32767;
    v = $urandom_range(0, lim);
    if ($urandom_range(0, 6) == 0) v = -v;
    return 16'(v);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w.op = (r < 60) ? OpUpdate : (r < 80) ? OpCheck : (r < 95) ? OpRead : 2'd3;
    w.agent = 4'($urandom);
    w.pos_x = pick_pos(cur_w, cur_cols);
    w.pos_y = pick_pos(cur_h, cur_rows);
    w.mark_index = 3'($urandom);
    return w;
  endfunction

  function automatic in_word_t mk(logic [1:0] op, logic [3:0] agent, int x, int y,
                                  logic [2:0] mi);
    in_word_t w;
    w.op = op;
    w.agent = agent;
    w.pos_x = 16'(x);
    w.pos_y = 16'(y);
    w.mark_index = mi;
    return w;
  endfunction

  task automatic random_run(int count);
    repeat (count) send_word(random_word());
  endtask

  initial begin
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgGridRows;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cur_rows = 12;
    cur_cols = 12;
    cur_w = 1067;
    cur_h = 800;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset grid, first update, no move, far and negative positions
    send_word(mk(OpCheck, 0, 0, 0, 0));
    send_word(mk(OpRead, 0, 0, 0, 0));
    send_word(mk(OpUpdate, 0, 0, 0, 0));
    send_word(mk(OpUpdate, 0, 16, 16, 0));
    send_word(mk(OpUpdate, 0, -15, -1, 0));
    send_word(mk(OpUpdate, 0, 32767, 32767, 7));
    send_word(mk(OpUpdate, 15, -32768, -32768, 0));
    send_word(mk(OpUpdate, 15, -1067, -800, 0));
    send_word(mk(OpUpdate, 1, 11 * 1067, 11 * 800, 0));
    send_word(mk(OpUpdate, 2, 5 * 1067, 5 * 800, 0));
    send_word(mk(OpCheck, 0, 0, 0, 0));
    send_word(mk(2'd3, 15, -1, -1, 7));
    for (int i = 0; i < 8; i++) send_word(mk(OpRead, 0, 0, 0, 3'(i)));
    send_word(mk(OpUpdate, 3, 8 * 1067, 2 * 800, 0));
    send_word(mk(OpCheck, 0, 0, 0, 0));
    drain_block();

    // One row of 64 columns: milestones are passed one by one
    set_grid(1, 127, 16, 65535);
    quiet = 1'b1;
    random_run(40);
    quiet = 1'b0;
    random_run(100);
    drain_block();

    // Full grid, unit cells; long receiver hold while words keep coming
    set_grid(64, 64, 0, 1);
    hold_req <= 1'b1;
    random_run(150);
    drain_block();

    // Empty grid: nothing marked, nothing reached
    set_grid(0, 5, 65535, 3);
    random_run(40);
    drain_block();

    // Shrunk grid: coverage beyond the whole grid
    set_grid(2, 2, 1067, 800);
    random_run(100);
    drain_block();

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/gct_pkg.sv
rtl/core/gct_if.sv
rtl/core/gct_div.sv
rtl/core/grid_coverage_tracker_core.sv
tb/gct_checker.sv
tb/tb.sv
